// ----- hw/rtl/line_substring_matcher_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Line substring matcher: assertion macros
// Shared forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef LINE_SUBSTRING_MATCHER_UNIT_MACROS_SVH
`define LINE_SUBSTRING_MATCHER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSM_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LSM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/lsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Line substring matcher package
// Constants and types shared by the window cells and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package lsm_pkg;

    // Byte that ends a line.
    localparam logic [7:0] NEWLINE_BYTE = 8'd10;

    // Saturation value of the line length counter.
    localparam logic [15:0] LENGTH_MAX = 16'hFFFF;

    // Number of term bytes held by the two pattern registers.
    localparam int TERM_BYTES = 16;

    // Configuration register indexes.
    localparam logic [1:0] REG_PATTERN_LOW    = 2'd0;
    localparam logic [1:0] REG_PATTERN_HIGH   = 2'd1;
    localparam logic [1:0] REG_PATTERN_LENGTH = 2'd2;

    // Control shared by every cell of the window chain.
    typedef struct packed {
        logic shift;  // a text byte enters the chain
        logic clear;  // the current line ends, all cells become empty
    } lsm_cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lsm_cell.sv -----
// ----------------------------------------------------------------------------
// Line substring matcher: window cell
// Holds one byte of the sliding line window, hands it to the next older
// cell on every shift and compares its incoming byte with one term byte.
// ----------------------------------------------------------------------------
`default_nettype none

module lsm_cell
    import lsm_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire lsm_cell_ctrl_t ctrl,
    input  wire logic [7:0]     in_byte,    // byte from the newer neighbour
    input  wire logic           in_valid,   // neighbour holds a byte of this line
    input  wire logic [7:0]     term_byte,  // term byte aligned to this cell
    input  wire logic           in_window,  // this cell lies under the term
    output logic [7:0]          out_byte,
    output logic                out_valid,
    output logic                ok          // cell agrees with the term after the shift
);

    logic [7:0] byte_reg;
    logic       valid_reg;
    logic       valid_next;

    // Compare the byte that this cell will hold after the shift.
    assign ok = !in_window || (in_valid && (in_byte == term_byte));

    // Occupancy follows the neighbour on a shift and empties at line end.
    always_comb
    begin
        valid_next = valid_reg;
        if (ctrl.clear)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Window byte, meaningful only while the cell is occupied.
    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            byte_reg <= in_byte;
        end
    end

    assign out_byte  = byte_reg;
    assign out_valid = valid_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/line_substring_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// Line substring matcher
// Splits a byte stream into lines and reports for each line whether the
// configured fixed search term occurs in it, together with the line length.
//
//   Channel   Direction  Item contents
//   s_axis    in         tdata: data_byte; tlast: stream_end (drops line)
//   m_axis    out        tdata: line_length; tuser: line_matched
//   cfg       in         write of pattern_low, pattern_high, pattern_length
//
// One item is taken per cycle; a newline gives its result on m_axis in the
// cycle after it is taken. The window chain compares all term positions in
// the cycle a byte enters, so the byte rate is set by that single compare.
// Reset empties the window and the line counters; the pattern registers
// reset to zero. A stalled result holds the output register and s_axis
// waits only while that register is full and not being taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "line_substring_matcher_unit_macros.svh"

module line_substring_matcher_unit
    import lsm_pkg::*;
#(
    parameter int PATTERN_MAX = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Text input
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // stream_end
    // Line results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [15:0] line_length
    output logic             m_axis_tuser,   // line_matched
    // Configuration writes
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata
);

    localparam logic [5:0] PM_W  = 6'(PATTERN_MAX);
    localparam logic [4:0] PM_L  = 5'(PATTERN_MAX);

    // Configuration registers.
    logic [63:0] pattern_low_reg;
    logic [63:0] pattern_high_reg;
    logic [4:0]  pattern_length_reg;

    // Line state and output register.
    logic [15:0] length_count_reg, length_count_next;
    logic        match_seen_reg, match_seen_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_matched_reg, out_matched_next;
    logic [15:0] out_length_reg, out_length_next;

    logic            accept;
    logic            is_newline;
    logic            line_end;
    logic            hit;
    logic [4:0]      len_eff;
    logic [5:0]      win_start;
    logic [15:0]     length_inc;
    logic [127:0]    term_bits;
    lsm_cell_ctrl_t  cell_ctrl;

    logic [7:0]             win_byte  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] win_valid;
    logic [PATTERN_MAX-1:0] cell_ok;

    // Configuration write port.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_low_reg    <= '0;
            pattern_high_reg   <= '0;
            pattern_length_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_PATTERN_LOW:    pattern_low_reg    <= cfg_wdata;
                REG_PATTERN_HIGH:   pattern_high_reg   <= cfg_wdata;
                REG_PATTERN_LENGTH: pattern_length_reg <= cfg_wdata[4:0];
                default:            ;
            endcase
        end
    end

    // Handshake and cell control.
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign is_newline    = (s_axis_tdata == NEWLINE_BYTE);
    assign line_end      = accept && (s_axis_tlast || is_newline);

    assign cell_ctrl.shift = accept && !s_axis_tlast;
    assign cell_ctrl.clear = line_end;

    // Term length clamped to the window, and the oldest cell under the term.
    assign len_eff   = (pattern_length_reg > PM_L) ? PM_L : pattern_length_reg;
    assign win_start = PM_W - {1'b0, len_eff};
    assign term_bits = {pattern_high_reg, pattern_low_reg};

    // Window chain: the newest byte enters at the top cell.
    for (genvar k = 0; k < PATTERN_MAX; k++)
    begin : g_cell
        localparam logic [5:0] POS = 6'(k);

        logic [7:0] in_byte;
        logic       in_valid;
        logic       in_window;
        logic [5:0] term_pos;
        logic [7:0] term_byte;

        if (k == PATTERN_MAX - 1)
        begin : g_top
            assign in_byte  = s_axis_tdata;
            assign in_valid = 1'b1;
        end
        else
        begin : g_mid
            assign in_byte  = win_byte[k+1];
            assign in_valid = win_valid[k+1];
        end

        // Term byte index for this cell is its distance from the oldest one.
        assign in_window = (POS >= win_start);
        assign term_pos  = POS - win_start;
        assign term_byte = term_bits[{term_pos[3:0], 3'b000} +: 8];

        lsm_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (cell_ctrl),
            .in_byte   (in_byte),
            .in_valid  (in_valid),
            .term_byte (term_byte),
            .in_window (in_window),
            .out_byte  (win_byte[k]),
            .out_valid (win_valid[k]),
            .ok        (cell_ok[k])
        );
    end

    // The term is seen when every cell under it agrees.
    assign hit = &cell_ok;

    // Line counters and result register.
    assign length_inc = (length_count_reg == LENGTH_MAX) ? length_count_reg
                                                         : length_count_reg + 16'd1;

    always_comb
    begin
        length_count_next = length_count_reg;
        match_seen_next   = match_seen_reg;
        out_valid_next    = out_valid_reg && !m_axis_tready;
        out_matched_next  = out_matched_reg;
        out_length_next   = out_length_reg;
        if (accept)
        begin
            if (s_axis_tlast)
            begin
                length_count_next = '0;
                match_seen_next   = 1'b0;
            end
            else if (is_newline)
            begin
                out_valid_next    = 1'b1;
                out_matched_next  = match_seen_reg || hit;
                out_length_next   = length_inc;
                length_count_next = '0;
                match_seen_next   = 1'b0;
            end
            else
            begin
                length_count_next = length_inc;
                match_seen_next   = match_seen_reg || hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_count_reg <= '0;
            match_seen_reg   <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            length_count_reg <= length_count_next;
            match_seen_reg   <= match_seen_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_matched_reg <= out_matched_next;
        out_length_reg  <= out_length_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_matched_reg;
    assign m_axis_tdata  = out_length_reg;

    // Checks on the line logic.
    `LSM_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        m_axis_tvalid && !m_axis_tready, !s_axis_tready,
        "input taken while a result is stalled")
    `LSM_ASSERT_NEXT(a_newline_gives_result, clk, rst_n,
        accept && !s_axis_tlast && is_newline, m_axis_tvalid,
        "newline did not produce a result")
    `LSM_ASSERT_NEXT(a_stream_end_clears, clk, rst_n,
        accept && s_axis_tlast, (length_count_reg == '0) && !match_seen_reg,
        "stream end left line state behind")
    `LSM_ASSERT_NEXT(a_empty_term_matches, clk, rst_n,
        accept && !s_axis_tlast && is_newline && (len_eff == '0), m_axis_tuser,
        "empty term did not match the line")

endmodule

`default_nettype wire

// ----- tb/sv/line_substring_matcher_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Line substring matcher testbench
// Feeds text items into the matcher and keeps a cycle-free model of the line
// state beside it. Each newline that the model sees queues one expected line
// result, which is checked against the next item taken from m_axis. Items
// start with a short directed set and continue with random lines under
// changing search terms. Both sides idle at random in most random phases.
// ----------------------------------------------------------------------------
module line_substring_matcher_unit_tb;
    import lsm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Index that no register decodes.
    localparam logic [1:0] REG_UNUSED = 2'd3;

    typedef struct packed {
        logic [7:0] data;
        logic       drop;
    } text_item_t;

    typedef struct packed {
        logic        matched;
        logic [15:0] length;
    } line_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // [7:0] data_byte
    logic        s_axis_tlast = 1'b0;   // stream_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] line_length
    logic        m_axis_tuser;          // line_matched
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [63:0] cfg_wdata = 64'd0;

    // Stimulus and checking state.
    text_item_t   pending_text[$];
    line_result_t expected_lines[$];
    int           mismatch_count = 0;
    int           item_total = 0;
    int           gap_left = 0;
    int           stall_left = 0;
    bit           idling_on = 1'b0;
    logic [7:0]   term_bytes[TERM_BYTES];
    int           len_plan[10] = '{1, 16, 31, 3, 0, 2, 8, 12, 20, 5};

    // Model copy of the registers and the line state.
    logic [63:0]  term_lo = 64'd0;
    logic [63:0]  term_hi = 64'd0;
    logic [4:0]   term_len = 5'd0;
    logic [7:0]   win_bytes[TERM_BYTES] = '{default: 8'd0};
    int           win_fill = 0;
    logic         line_hit = 1'b0;
    logic [15:0]  line_len = 16'd0;

    line_substring_matcher_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    // Clock generation.
    always #1 clk = ~clk;

    // Effective term length, with oversized settings clipped to the window.
    function automatic int term_span();
        return (term_len > TERM_BYTES) ? TERM_BYTES : int'(term_len);
    endfunction

    function automatic logic [7:0] term_byte_at(input int i);
        return (i < 8) ? term_lo[i*8 +: 8] : term_hi[(i-8)*8 +: 8];
    endfunction

    // The newest bytes of the line are compared against the whole term.
    function automatic bit window_holds_term();
        int n;
        n = term_span();
        if (n == 0)
            return 1'b1;
        if (win_fill < n)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            if (win_bytes[TERM_BYTES-n+i] != term_byte_at(i))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic clear_line_state();
        for (int k = 0; k < TERM_BYTES; k++)
            win_bytes[k] = 8'd0;
        win_fill = 0;
        line_hit = 1'b0;
        line_len = 16'd0;
    endtask

    // Advances the line model by one text item and reports any line result.
    task automatic advance_line_model(input text_item_t it, output bit produced,
                                      output line_result_t res);
        produced = 1'b0;
        res = '0;
        if (it.drop)
        begin
            clear_line_state();
            return;
        end
        for (int k = 0; k < TERM_BYTES - 1; k++)
            win_bytes[k] = win_bytes[k+1];
        win_bytes[TERM_BYTES-1] = it.data;
        if (win_fill < TERM_BYTES)
            win_fill++;
        if (line_len != LENGTH_MAX)
            line_len++;
        if (window_holds_term())
            line_hit = 1'b1;
        if (it.data == NEWLINE_BYTE)
        begin
            res.matched = line_hit;
            res.length = line_len;
            produced = 1'b1;
            clear_line_state();
        end
    endtask

    // Text driver: presents pending items, with random gaps after some.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            gap_left <= 0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (gap_left > 0)
            begin
                gap_left <= gap_left - 1;
                s_axis_tvalid <= 1'b0;
            end
            else if (pending_text.size() != 0)
            begin
                text_item_t it;
                it = pending_text.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= it.data;
                s_axis_tlast <= it.drop;
                if (idling_on && $urandom_range(0, 7) == 0)
                    gap_left <= $urandom_range(1, 14);
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Result sink: stalls in random bursts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (idling_on && $urandom_range(0, 9) == 0)
                stall_left <= $urandom_range(1, 14);
        end
    end

    // Monitor: checks taken results first, then predicts from taken text.
    always @(posedge clk)
    begin
        line_result_t want;
        text_item_t   taken;
        line_result_t got_res;
        bit           got;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_lines.size() == 0)
                begin
                    $display("%0t: line result: expected none, actual %0b/%0d",
                             $time, m_axis_tuser, m_axis_tdata);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    if (m_axis_tuser !== want.matched)
                    begin
                        $display("%0t: line_matched: expected %0b, actual %0b",
                                 $time, want.matched, m_axis_tuser);
                        mismatch_count++;
                    end
                    if (m_axis_tdata !== want.length)
                    begin
                        $display("%0t: line_length: expected %0d, actual %0d",
                                 $time, want.length, m_axis_tdata);
                        mismatch_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                taken.data = s_axis_tdata;
                taken.drop = s_axis_tlast;
                advance_line_model(taken, got, got_res);
                if (got)
                    expected_lines.insert(expected_lines.size(), got_res);
            end
        end
    end

    task automatic push_byte(input logic [7:0] b);
        text_item_t it;
        it.data = b;
        it.drop = 1'b0;
        pending_text.insert(pending_text.size(), it);
        item_total++;
    endtask

    // A stream end carries a random data byte, which the block ignores.
    task automatic push_drop();
        text_item_t it;
        it.data = 8'($urandom_range(0, 255));
        it.drop = 1'b1;
        pending_text.insert(pending_text.size(), it);
        item_total++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i]);
    endtask

    // Waits until every item is taken and every result has come out.
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_text.size() != 0 || s_axis_tvalid || expected_lines.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PATTERN_LOW:    term_lo = data;
            REG_PATTERN_HIGH:   term_hi = data;
            REG_PATTERN_LENGTH: term_len = data[4:0];
            default:            ;
        endcase
    endtask

    // Loads term_bytes into the pattern registers; upper length bits are noise.
    task automatic load_term(input logic [4:0] len_val);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i < 8; i++)
        begin
            lo[i*8 +: 8] = term_bytes[i];
            hi[i*8 +: 8] = term_bytes[i+8];
        end
        write_reg(REG_PATTERN_LOW, lo);
        write_reg(REG_PATTERN_HIGH, hi);
        write_reg(REG_PATTERN_LENGTH, {$urandom, 27'($urandom), len_val});
    endtask

    // Text bytes lean on the term's own bytes so that near misses are common.
    function automatic logic [7:0] pick_text_byte();
        int         r;
        int         n;
        logic [7:0] b;
        r = $urandom_range(0, 9);
        n = term_span();
        if (r < 6 && n > 0)
            b = term_bytes[$urandom_range(0, n - 1)];
        else if (r < 9)
            b = 8'h61 + 8'($urandom_range(0, 3));
        else
            b = 8'($urandom_range(0, 255));
        if (b == NEWLINE_BYTE)
            b = 8'h65;
        return b;
    endfunction

    // One random line: mostly well formed, some noise, some cut by a stream end.
    task automatic add_random_line();
        int kind;
        int n;
        int at;
        bit insert;
        kind = $urandom_range(0, 99);
        n = $urandom_range(0, 20);
        at = $urandom_range(0, n);
        insert = ($urandom_range(0, 9) < 4);
        if (kind < 10)
        begin
            repeat (n) push_byte(8'($urandom_range(0, 255)));
            push_byte(NEWLINE_BYTE);
        end
        else
        begin
            for (int i = 0; i <= n; i++)
            begin
                if (i == at && insert)
                begin
                    for (int j = 0; j < term_span(); j++)
                        push_byte(term_bytes[j]);
                end
                if (i < n)
                    push_byte(pick_text_byte());
            end
            if (kind < 20)
                push_drop();
            else
                push_byte(NEWLINE_BYTE);
        end
    endtask

    // Main sequence.
    initial
    begin
        int start;
        for (int i = 0; i < TERM_BYTES; i++)
            term_bytes[i] = 8'd0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Empty term after reset: every line matches; a stream end drops a line.
        push_text("\n");
        push_byte(8'hFF);
        push_byte(8'h00);
        push_byte(NEWLINE_BYTE);
        push_byte(8'h78);
        push_drop();
        push_text("\n");
        wait_drained();

        // Term ending in a newline can match.
        term_bytes[0] = 8'h61;
        term_bytes[1] = NEWLINE_BYTE;
        load_term(5'd2);
        push_text("xa\n");
        wait_drained();

        // Term with a newline before its end never matches.
        term_bytes[0] = NEWLINE_BYTE;
        term_bytes[1] = 8'h62;
        load_term(5'd2);
        push_text("a\nb\n");
        wait_drained();

        // Two-byte term inside a line, at its start and missing.
        term_bytes[0] = 8'h7A;
        term_bytes[1] = 8'h71;
        load_term(5'd2);
        push_text("xxzqxx\n");
        push_text("zq\n");
        push_text("zxq\n");
        wait_drained();

        // Random phases, each under its own term; odd phases end mid-line.
        for (int p = 0; p < 10; p++)
        begin
            idling_on = (p < 8) && (p != 3);
            for (int i = 0; i < TERM_BYTES; i++)
                term_bytes[i] = (p % 2 == 0) ? 8'h61 + 8'($urandom_range(0, 2))
                                             : 8'($urandom_range(0, 255));
            load_term(5'(len_plan[p]));
            if (p == 4)
                write_reg(REG_UNUSED, {$urandom, $urandom});
            start = item_total;
            while (item_total - start < 60)
                add_random_line();
            if (p % 2 == 1)
                repeat ($urandom_range(1, 6)) push_byte(pick_text_byte());
            wait_drained();
        end

        if (mismatch_count == 0 && expected_lines.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Run limit.
    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
